// ----- hw/rtl/npt_pkg.sv -----
// Package for the nearest point table: payload structs, slot layout, codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package npt_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int COORD_BITS    = 24;
  localparam int ID_BITS       = 32;
  localparam int PROD_W        = 2 * COORD_BITS;
  localparam int DIST_W        = 2 * COORD_BITS + 2;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_QUERY  = 3'd2;
  localparam logic [2:0] FN_CLEAR  = 3'd3;
  localparam logic [2:0] FN_MEMBER = 3'd4;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_DUP    = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;
  localparam logic [1:0] STS_ABSENT = 2'd3;

  typedef struct packed {
    logic [2:0]                    func;
    logic [ID_BITS-1:0]            node_id;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] found_id;
  } out_item_t;

  typedef struct packed {
    logic                   valid;
    logic [ID_BITS-1:0]     ident;
    logic [COORD_BITS-1:0]  pz;
    logic [COORD_BITS-1:0]  py;
    logic [COORD_BITS-1:0]  px;
  } slot_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    logic  load;
    axis_t axis;
    logic  clr;
    logic  add;
  } sq_ctl_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIND,
    ST_FIN,
    ST_CLR,
    ST_QX,
    ST_QY,
    ST_QZ,
    ST_QS,
    ST_QA,
    ST_QEND,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/npt_store.sv -----
// Slot memory of the nearest point table: one write port, one registered read.
// Depends on npt_pkg for the slot layout.
`timescale 1ns / 1ps
`default_nettype none
module npt_store #(
  parameter int MAX_NODES = npt_pkg::MAX_NODES_DEF,
  parameter int IDX_W     = $clog2(MAX_NODES)
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire npt_pkg::slot_t wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output npt_pkg::slot_t      rd_data
);
  import npt_pkg::*;

  slot_t mem [MAX_NODES];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/npt_sq_unit.sv -----
// Shared squared-distance unit: one axis difference, one squarer, accumulator.
// Depends on npt_pkg for slot layout, payload and control struct.
`timescale 1ns / 1ps
`default_nettype none
module npt_sq_unit (
  input  wire logic                      clk,
  input  wire npt_pkg::sq_ctl_t          ctl,
  input  wire npt_pkg::slot_t            slot,
  input  wire npt_pkg::in_item_t         qry,
  output logic [npt_pkg::DIST_W-1:0]     sq_dist
);
  import npt_pkg::*;

  logic signed [COORD_BITS:0] slot_c;
  logic signed [COORD_BITS:0] qry_c;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        neg;
  logic [COORD_BITS-1:0]      mag_nxt;
  logic [COORD_BITS-1:0]      mag_r;
  logic [PROD_W-1:0]          prod_r;
  logic [DIST_W-1:0]          acc_r;

  always_comb begin
    case (ctl.axis)
      AX_X: begin
        slot_c = {slot.px[COORD_BITS-1], slot.px};
        qry_c  = {qry.pos_x[COORD_BITS-1], qry.pos_x};
      end
      AX_Y: begin
        slot_c = {slot.py[COORD_BITS-1], slot.py};
        qry_c  = {qry.pos_y[COORD_BITS-1], qry.pos_y};
      end
      AX_Z: begin
        slot_c = {slot.pz[COORD_BITS-1], slot.pz};
        qry_c  = {qry.pos_z[COORD_BITS-1], qry.pos_z};
      end
      default: begin
        slot_c = '0;
        qry_c  = '0;
      end
    endcase
  end

  assign diff    = slot_c - qry_c;
  assign neg     = -diff;
  assign mag_nxt = diff[COORD_BITS] ? neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= mag_nxt;
    end
    prod_r <= mag_r * mag_r;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= acc_r + DIST_W'(prod_r);
    end
  end

  // last square joins the sum on the compare cycle
  assign sq_dist = acc_r + DIST_W'(prod_r);

endmodule
`default_nettype wire

// ----- hw/rtl/npt_seq.sv -----
// Sequencer of the nearest point table: slot scans, sweeps, result register.
// Depends on npt_pkg; drives npt_store and npt_sq_unit.
`timescale 1ns / 1ps
`default_nettype none
module npt_seq #(
  parameter int MAX_NODES = npt_pkg::MAX_NODES_DEF,
  parameter int IDX_W     = $clog2(MAX_NODES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire npt_pkg::in_item_t     in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output npt_pkg::out_item_t         out_data,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_addr,
  output npt_pkg::slot_t             wr_data,
  output logic [IDX_W-1:0]           rd_addr,
  input  wire npt_pkg::slot_t        rd_data,
  output npt_pkg::sq_ctl_t           sq_ctl,
  output npt_pkg::in_item_t          qry,
  input  wire logic [npt_pkg::DIST_W-1:0] sq_dist
);
  import npt_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_NODES - 1);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  in_item_t           cmd_r;
  logic               hit_r, free_r, have_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r;
  logic [DIST_W-1:0]  best_r;
  logic [ID_BITS-1:0] best_id_r;
  out_item_t          res_r, out_r;
  logic               out_valid_r;
  logic               accept, is_last, slot_hit, out_load;

  assign accept   = in_valid && !in_stall;
  assign is_last  = (idx_r == LAST);
  assign slot_hit = rd_data.valid && (rd_data.ident == cmd_r.node_id);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign rd_addr  = idx_nxt;
  assign qry      = cmd_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_INIT: begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
        if (is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          case (in_data.func)
            FN_INSERT, FN_REMOVE, FN_MEMBER: state_nxt = ST_FIND;
            FN_QUERY:                        state_nxt = ST_QX;
            FN_CLEAR:                        state_nxt = ST_CLR;
            default:                         state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
        if (is_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_DONE;
      ST_CLR: begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
        if (is_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_QX: begin
        if (rd_data.valid) begin
          state_nxt = ST_QY;
        end else if (is_last) begin
          state_nxt = ST_QEND;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      ST_QY:   state_nxt = ST_QZ;
      ST_QZ:   state_nxt = ST_QS;
      ST_QS:   state_nxt = ST_QA;
      ST_QA: begin
        if (is_last) begin
          state_nxt = ST_QEND;
        end else begin
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          state_nxt = ST_QX;
        end
      end
      ST_QEND: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = '{valid: 1'b0, ident: cmd_r.node_id, pz: cmd_r.pos_z,
                 py: cmd_r.pos_y, px: cmd_r.pos_x};
    sq_ctl   = '{load: 1'b0, axis: AX_X, clr: 1'b0, add: 1'b0};
    case (state_r)
      ST_INIT, ST_CLR: wr_en = 1'b1;
      ST_FIN: begin
        if (cmd_r.func == FN_INSERT) begin
          wr_en         = !hit_r && free_r;
          wr_addr       = free_idx_r;
          wr_data.valid = 1'b1;
        end else if (cmd_r.func == FN_REMOVE) begin
          wr_en   = hit_r;
          wr_addr = hit_idx_r;
        end
      end
      ST_QX: sq_ctl = '{load: 1'b1, axis: AX_X, clr: 1'b1, add: 1'b0};
      ST_QY: sq_ctl = '{load: 1'b1, axis: AX_Y, clr: 1'b0, add: 1'b0};
      ST_QZ: sq_ctl = '{load: 1'b1, axis: AX_Z, clr: 1'b0, add: 1'b1};
      ST_QS: sq_ctl = '{load: 1'b0, axis: AX_Z, clr: 1'b0, add: 1'b1};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        have_r <= 1'b0;
      end else if (state_r == ST_FIND) begin
        if (slot_hit && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!rd_data.valid && !free_r) begin
          free_r <= 1'b1;
        end
      end else if (state_r == ST_QA) begin
        if (!have_r || sq_dist < best_r) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
      res_r <= '0;
    end
    if (state_r == ST_FIND) begin
      if (slot_hit && !hit_r) begin
        hit_idx_r <= idx_r;
      end
      if (!rd_data.valid && !free_r) begin
        free_idx_r <= idx_r;
      end
    end
    if (state_r == ST_QA && (!have_r || sq_dist < best_r)) begin
      best_r    <= sq_dist;
      best_id_r <= rd_data.ident;
    end
    if (state_r == ST_FIN) begin
      case (cmd_r.func)
        FN_INSERT: res_r.status <= hit_r ? STS_DUP : (free_r ? STS_OK : STS_FULL);
        FN_MEMBER: res_r.status <= hit_r ? STS_OK : STS_ABSENT;
        default:   res_r.status <= STS_OK;
      endcase
    end
    if (state_r == ST_QEND) begin
      res_r.status   <= have_r ? STS_OK : STS_ABSENT;
      res_r.found_id <= have_r ? best_id_r : '0;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_wr_only_sweep_or_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_INIT || state_r == ST_CLR || state_r == ST_FIN))
    else $error("slot write outside sweep or finish");

  a_dup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && cmd_r.func == FN_INSERT && hit_r) |-> !wr_en)
    else $error("insert of a present id wrote the table");

  a_first_slot_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QA && !have_r) |=> have_r)
    else $error("first valid slot of a query not taken as best");

  a_query_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QEND) |=> ((res_r.status == STS_ABSENT) == !$past(have_r)))
    else $error("query status disagrees with scan result");

endmodule
`default_nettype wire

// ----- hw/rtl/nearest_point_table.sv -----
// Nearest point table: insert, remove, clear, membership and nearest query.
// Insert, remove and membership scan every slot and then finish in ST_FIN; clear
// sweeps every slot; a nearest query passes an empty slot in ST_QX and takes an
// occupied one through ST_QX, ST_QY, ST_QZ, ST_QS and ST_QA on the shared squarer.
// One item at a time. Reset (rst_n low, synchronous) starts a sweep that marks
// every slot empty; in_stall stays high until it ends.
`timescale 1ns / 1ps
`default_nettype none
module nearest_point_table #(
  parameter int MAX_NODES = npt_pkg::MAX_NODES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire npt_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output npt_pkg::out_item_t   out_data
);
  import npt_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_t             wr_data;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_data;
  sq_ctl_t           sq_ctl;
  in_item_t          qry;
  logic [DIST_W-1:0] sq_dist;

  npt_seq #(
    .MAX_NODES (MAX_NODES),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .sq_ctl    (sq_ctl),
    .qry       (qry),
    .sq_dist   (sq_dist)
  );

  npt_store #(
    .MAX_NODES (MAX_NODES),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  npt_sq_unit u_sq (
    .clk     (clk),
    .ctl     (sq_ctl),
    .slot    (rd_data),
    .qry     (qry),
    .sq_dist (sq_dist)
  );

endmodule
`default_nettype wire

// ----- verif/nearest_point_table_checker.sv -----
// Checker for the nearest point table: watches both channels, keeps its own
// copy of the point table, predicts each result and compares it on transfer.
// Depends on npt_pkg for the payload structs and the command and status codes.
`timescale 1ns / 1ps
module nearest_point_table_checker #(
  parameter int TABLE_DEPTH = npt_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  npt_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  npt_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 waiting_results
);
  import npt_pkg::*;

  logic                         slot_used [TABLE_DEPTH];
  logic [ID_BITS-1:0]           slot_ident [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] slot_x [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] slot_y [TABLE_DEPTH];
  logic signed [COORD_BITS-1:0] slot_z [TABLE_DEPTH];
  int                           occupied;
  out_item_t                    expected_q [$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int find_slot(logic [ID_BITS-1:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && slot_used[i] && slot_ident[i] == id) hit = i;
    return hit;
  endfunction

  function automatic logic [63:0] dist_sq(int s, in_item_t q);
    longint dx, dy, dz;
    dx = longint'($signed(slot_x[s])) - longint'($signed(q.pos_x));
    dy = longint'($signed(slot_y[s])) - longint'($signed(q.pos_y));
    dz = longint'($signed(slot_z[s])) - longint'($signed(q.pos_z));
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  // Applies one command to the shadow table and returns the expected result.
  function automatic out_item_t table_step(in_item_t c);
    out_item_t   r;
    int          hit;
    int          best_slot;
    logic [63:0] best_d;
    logic [63:0] d;
    r.status   = STS_OK;
    r.found_id = '0;
    best_d     = '0;
    case (c.func)
      FN_INSERT: begin
        if (find_slot(c.node_id) >= 0) begin
          r.status = STS_DUP;
        end else if (occupied >= TABLE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          hit = -1;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && !slot_used[i]) hit = i;
          slot_used[hit]  = 1'b1;
          slot_ident[hit] = c.node_id;
          slot_x[hit]     = c.pos_x;
          slot_y[hit]     = c.pos_y;
          slot_z[hit]     = c.pos_z;
          occupied++;
        end
      end
      FN_REMOVE: begin
        hit = find_slot(c.node_id);
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          occupied--;
        end
      end
      FN_QUERY: begin
        best_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (slot_used[i]) begin
            d = dist_sq(i, c);
            // strict compare: lowest slot keeps a tie
            if (best_slot < 0 || d < best_d) begin
              best_slot = i;
              best_d    = d;
            end
          end
        end
        if (best_slot < 0) r.status = STS_ABSENT;
        else r.found_id = slot_ident[best_slot];
      end
      FN_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
        occupied = 0;
      end
      FN_MEMBER: begin
        if (find_slot(c.node_id) < 0) r.status = STS_ABSENT;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
      occupied = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected",
                          32'(out_data.status), 32'(0));
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.found_id !== want.found_id)
            report_mismatch("found_id", out_data.found_id, want.found_id);
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(), table_step(in_data));
    end
    waiting_results = expected_q.size();
  end

endmodule

// ----- verif/nearest_point_table_tb.sv -----
// Testbench top for the nearest point table: clock, reset, command stimulus
// with random idling on both channels, and the final verdict.
// Depends on npt_pkg, nearest_point_table and nearest_point_table_checker.
`timescale 1ns / 1ps
module nearest_point_table_tb;
  import npt_pkg::*;

  localparam int         DEPTH          = MAX_NODES_DEF;
  localparam int         ITEM_TARGET    = 950;
  localparam logic [2:0] FN_UNUSED_LO   = 3'd5;
  localparam logic [2:0] FN_UNUSED_MID  = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI   = 3'd7;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        waiting_results;
  int        sent_count;
  logic      quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_point_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  nearest_point_table_checker #(.TABLE_DEPTH(DEPTH)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .waiting_results(waiting_results)
  );

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int          v;
    logic [31:0] w;
    v = $urandom_range(0, 9);
    w = $urandom();
    case (v)
      0: return C_MAX;
      1: return C_MIN;
      2, 3, 4: begin
        v = $urandom_range(0, 15) - 8;
        return v[COORD_BITS-1:0];
      end
      default: return w[COORD_BITS-1:0];
    endcase
  endfunction

  function automatic in_item_t mk(logic [2:0] fn, logic [ID_BITS-1:0] id,
                                  logic signed [COORD_BITS-1:0] x,
                                  logic signed [COORD_BITS-1:0] y,
                                  logic signed [COORD_BITS-1:0] z);
    in_item_t it;
    it.func    = fn;
    it.node_id = id;
    it.pos_x   = x;
    it.pos_y   = y;
    it.pos_z   = z;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_rand(logic [2:0] fn, logic [ID_BITS-1:0] id);
    send(mk(fn, id, rand_coord(), rand_coord(), rand_coord()));
  endtask

  // short session over a small id pool so ids collide, plus unused codes and stray ids
  task automatic run_session();
    logic [ID_BITS-1:0] pool_base;
    logic [ID_BITS-1:0] id;
    int                 n;
    int                 r;
    pool_base = $urandom();
    n         = $urandom_range(4, 24);
    quiet     = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) send_rand(FN_CLEAR, $urandom());
    repeat (n) begin
      r  = $urandom_range(0, 99);
      id = pool_base + $urandom_range(0, 15);
      if (r < 35) send_rand(FN_INSERT, id);
      else if (r < 60) send_rand(FN_QUERY, $urandom());
      else if (r < 75) send_rand(FN_REMOVE, id);
      else if (r < 88) send_rand(FN_MEMBER, id);
      else if (r < 91) send_rand(FN_CLEAR, $urandom());
      else if (r < 94) send_rand(3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)), $urandom());
      else if (r < 97) send_rand(FN_MEMBER, $urandom());
      else send_rand(FN_INSERT, $urandom());
    end
  endtask

  // fill every slot, then exercise the full table
  task automatic fill_table();
    logic [ID_BITS-1:0] base;
    base  = $urandom();
    quiet = 1'b0;
    send_rand(FN_CLEAR, base);
    for (int i = 0; i < DEPTH; i++) send_rand(FN_INSERT, base + i);
    send_rand(FN_INSERT, base + DEPTH);
    send_rand(FN_INSERT, base + 3);
    repeat (4) send_rand(FN_QUERY, $urandom());
    repeat (3) send_rand(FN_REMOVE, base + $urandom_range(0, DEPTH - 1));
    send_rand(FN_MEMBER, base + $urandom_range(0, DEPTH - 1));
    repeat (4) send_rand(FN_INSERT, base + DEPTH + $urandom_range(1, 3));
    repeat (2) send_rand(FN_QUERY, $urandom());
  endtask

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  initial begin
    logic filled;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    sent_count = 0;
    filled     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // empty table, absent ids
    send(mk(FN_QUERY, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_MEMBER, 32'h5, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_REMOVE, 32'h5, 24'sd0, 24'sd0, 24'sd0));
    // extreme ids and corners
    send(mk(FN_INSERT, 32'h0, C_MAX, C_MAX, C_MAX));
    send(mk(FN_INSERT, 32'hFFFF_FFFF, C_MIN, C_MIN, C_MIN));
    send(mk(FN_INSERT, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_MEMBER, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_QUERY, 32'h0, C_MIN, C_MIN, C_MIN));
    send(mk(FN_QUERY, 32'h0, C_MAX, C_MAX, C_MAX));
    // equal distances: lowest slot wins
    send(mk(FN_INSERT, 32'h7, 24'sd1, 24'sd0, 24'sd0));
    send(mk(FN_INSERT, 32'h9, -24'sd1, 24'sd0, 24'sd0));
    send(mk(FN_QUERY, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    // freed slot reused first
    send(mk(FN_REMOVE, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_INSERT, 32'h2A, 24'sd0, 24'sd1, 24'sd0));
    send(mk(FN_QUERY, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_REMOVE, 32'h7, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_QUERY, 32'h0, -24'sd1, 24'sd0, 24'sd0));
    send(mk(FN_UNUSED_LO, 32'hFFFF_FFFF, C_MIN, C_MAX, C_MIN));
    send(mk(FN_UNUSED_MID, 32'h0, C_MAX, C_MIN, C_MAX));
    send(mk(FN_UNUSED_HI, 32'h9, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_MEMBER, 32'h9, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_CLEAR, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_QUERY, 32'h0, 24'sd0, 24'sd0, 24'sd0));
    send(mk(FN_MEMBER, 32'hFFFF_FFFF, 24'sd0, 24'sd0, 24'sd0));

    while (sent_count < ITEM_TARGET) begin
      if (!filled && sent_count >= 300) begin
        fill_table();
        filled = 1'b1;
      end else begin
        run_session();
      end
    end
    in_valid = 1'b0;
    quiet    = 1'b0;

    while (waiting_results != 0) @(posedge clk);
    repeat (5 * DEPTH + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("nearest_point_table_tb OK");
    end else begin
      $display("nearest_point_table_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout");
    $display("nearest_point_table_tb NOT OK");
    $finish;
  end

endmodule
